// ===== design/calendar_to_epoch_seconds_assert.svh =====
// Assertion macros used by the calendar to epoch seconds checker
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// same-cycle implication
`define C2E_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define C2E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== design/c2e_pkg.sv =====
// Shared constants and helper functions for the calendar to epoch seconds block
package c2e_pkg;

   localparam int YEAR_W  = 15;
   localparam int YPOS_W  = 16;
   localparam int TOD_W   = 17;
   localparam int DAYB_W  = 10;
   localparam int DAYS_W  = 25;
   localparam int EPOCH_W = 40;
   localparam int PROD_W  = 42;
   localparam int YDAY_W  = 9;
   localparam int WDAY_W  = 3;
   localparam int MOD_W   = 27;
   localparam int QUART_W = 14;
   localparam int Q100_W  = 9;
   localparam int Q400_W  = 7;
   localparam int RECIP_W = 17;
   localparam int DPROD_W = YPOS_W + RECIP_W;

   // reciprocal constants, exact for any 16-bit unsigned operand
   localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
   localparam int                 SHIFT_100 = 23;
   localparam logic [RECIP_W-1:0] RECIP_400 = 17'd83887;
   localparam int                 SHIFT_400 = 25;

   localparam logic signed [YEAR_W-1:0] YEAR_LIMIT = 15'sd10000;
   localparam logic [3:0]               DECEMBER   = 4'd11;
   localparam logic [3:0]               FEBRUARY   = 4'd1;

   // year + 20000 keeps every year positive; 20000 is a multiple of 400
   localparam logic [YPOS_W-1:0] YPOS_BIAS  = 16'd21900;
   localparam logic [YPOS_W-1:0] EPOCH_YPOS = 16'd21970;
   // leap days removed by the bias plus leap days before 1970
   localparam logic signed [DAYS_W-1:0] DAYS_BIAS = 25'sd5327;
   localparam logic signed [DAYS_W-1:0] DAYS_PER_YEAR = 25'sd365;

   localparam logic [6:0]  SECS_PER_MINUTE = 7'd60;
   localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
   localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;

   // makes the day count positive and adds the Thursday offset of the epoch
   localparam logic [MOD_W-1:0] MOD7_BIAS = 27'd7340036;

   function automatic logic [YDAY_W-1:0] days_before(input logic [3:0] mon);
      logic [YDAY_W-1:0] d;
      unique case (mon)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

   // 8 is 1 mod 7, so octal digits fold without changing the residue
   function automatic logic [WDAY_W-1:0] mod7(input logic [MOD_W-1:0] n);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = '0;
      for (int i = 0; i < MOD_W / 3; i++) begin
         s1 = s1 + 6'(n[3*i +: 3]);
      end
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 4'(s2[3]) + 4'(s2[2:0]);
      return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
   endfunction

endpackage

// ===== design/calendar_to_epoch_seconds.sv =====
// Five pipeline stages with valid bits: input register, quotients, day count, day
// seconds and weekday, result register. One transfer per cycle while rsp_stall is low;
// a stage loads whenever it is empty or its contents move on, so bubbles close up.
// The stage chain is set by the year divide, the day sum and the 86400 multiply.
// Reset clears the stage valid bits only; payload registers are not reset.
module calendar_to_epoch_seconds (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [5:0]                          req_second,
   input  logic [5:0]                          req_minute,
   input  logic [4:0]                          req_hour,
   input  logic [4:0]                          req_month_day,
   input  logic [3:0]                          req_month_index,
   input  logic signed [c2e_pkg::YEAR_W-1:0]   req_years_since_1900,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [c2e_pkg::EPOCH_W-1:0]  rsp_epoch_seconds,
   output logic [c2e_pkg::YDAY_W-1:0]          rsp_day_of_year,
   output logic [c2e_pkg::WDAY_W-1:0]          rsp_day_of_week,
   output logic                                rsp_out_of_range
);

   // pipeline control
   logic [5:1] valid_ff;
   logic [5:1] valid_in;
   logic [6:1] load;

   always_comb begin
      load[6] = !rsp_stall;
      for (int j = 5; j >= 1; j--) begin
         load[j] = !valid_ff[j] || load[j+1];
      end
      valid_in[1] = load[1] ? req_valid : valid_ff[1];
      for (int j = 2; j <= 5; j++) begin
         valid_in[j] = load[j] ? valid_ff[j-1] : valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[1];
   assign rsp_valid = valid_ff[5];

   // stage 1: input register
   logic [5:0]                        s1_second_ff;
   logic [5:0]                        s1_minute_ff;
   logic [4:0]                        s1_hour_ff;
   logic [4:0]                        s1_mday_ff;
   logic [3:0]                        s1_month_ff;
   logic signed [c2e_pkg::YEAR_W-1:0] s1_year_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s1_second_ff <= req_second;
         s1_minute_ff <= req_minute;
         s1_hour_ff   <= req_hour;
         s1_mday_ff   <= req_month_day;
         s1_month_ff  <= req_month_index;
         s1_year_ff   <= req_years_since_1900;
      end
   end

   logic [3:0]                        s1_mon_sat;
   logic signed [c2e_pkg::DAYB_W-1:0] s1_dayb;
   logic [c2e_pkg::TOD_W-1:0]         s1_tod;
   logic [c2e_pkg::YPOS_W-1:0]        s1_ypos;
   logic [c2e_pkg::YPOS_W-1:0]        s1_yprev;
   logic                              s1_oor;
   logic [c2e_pkg::Q100_W-1:0]        s1_q100;
   logic [c2e_pkg::Q400_W-1:0]        s1_q400;
   logic [c2e_pkg::Q100_W-1:0]        s1_lq100;
   logic [c2e_pkg::Q400_W-1:0]        s1_lq400;

   always_comb begin
      s1_mon_sat = (s1_month_ff > c2e_pkg::DECEMBER) ? c2e_pkg::DECEMBER : s1_month_ff;
      s1_dayb    = signed'(c2e_pkg::DAYB_W'(c2e_pkg::days_before(s1_mon_sat)))
                   + signed'(c2e_pkg::DAYB_W'(s1_mday_ff)) - 10'sd1;
      s1_tod     = c2e_pkg::TOD_W'(s1_second_ff)
                   + c2e_pkg::TOD_W'(s1_minute_ff) * c2e_pkg::TOD_W'(c2e_pkg::SECS_PER_MINUTE)
                   + c2e_pkg::TOD_W'(s1_hour_ff) * c2e_pkg::TOD_W'(c2e_pkg::SECS_PER_HOUR);
      s1_ypos    = c2e_pkg::YPOS_W'(s1_year_ff) + c2e_pkg::YPOS_BIAS;
      s1_yprev   = s1_ypos - 16'd1;
      s1_oor     = (s1_year_ff > c2e_pkg::YEAR_LIMIT) || (s1_year_ff < -c2e_pkg::YEAR_LIMIT);
   end

   c2e_div100 u_div_year (
      .value   (s1_ypos),
      .quot100 (s1_q100),
      .quot400 (s1_q400)
   );

   c2e_div100 u_div_prev (
      .value   (s1_yprev),
      .quot100 (s1_lq100),
      .quot400 (s1_lq400)
   );

   // stage 2: quotients
   logic [c2e_pkg::YPOS_W-1:0]        s2_ypos_ff;
   logic [c2e_pkg::Q100_W-1:0]        s2_q100_ff;
   logic [c2e_pkg::Q400_W-1:0]        s2_q400_ff;
   logic [c2e_pkg::QUART_W-1:0]       s2_lquart_ff;
   logic [c2e_pkg::Q100_W-1:0]        s2_lq100_ff;
   logic [c2e_pkg::Q400_W-1:0]        s2_lq400_ff;
   logic [c2e_pkg::TOD_W-1:0]         s2_tod_ff;
   logic signed [c2e_pkg::DAYB_W-1:0] s2_dayb_ff;
   logic                              s2_late_ff;
   logic                              s2_oor_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s2_ypos_ff   <= s1_ypos;
         s2_q100_ff   <= s1_q100;
         s2_q400_ff   <= s1_q400;
         s2_lquart_ff <= s1_yprev[c2e_pkg::YPOS_W-1:2];
         s2_lq100_ff  <= s1_lq100;
         s2_lq400_ff  <= s1_lq400;
         s2_tod_ff    <= s1_tod;
         s2_dayb_ff   <= s1_dayb;
         s2_late_ff   <= s1_mon_sat > c2e_pkg::FEBRUARY - 4'd0 - 4'd0 ? 1'b1 : 1'b0;
         s2_oor_ff    <= s1_oor;
      end
   end

   logic [c2e_pkg::YPOS_W-1:0]        s2_rem100;
   logic [c2e_pkg::YPOS_W-1:0]        s2_rem400;
   logic                              s2_leap;
   logic signed [c2e_pkg::DAYB_W-1:0] s2_yday;
   logic signed [c2e_pkg::DAYS_W-1:0] s2_leaps;
   logic signed [c2e_pkg::DAYS_W-1:0] s2_yrel;
   logic signed [c2e_pkg::DAYS_W-1:0] s2_days;

   always_comb begin
      s2_rem100 = s2_ypos_ff - c2e_pkg::YPOS_W'(c2e_pkg::YPOS_W'(s2_q100_ff) * 16'd100);
      s2_rem400 = s2_ypos_ff - c2e_pkg::YPOS_W'(c2e_pkg::YPOS_W'(s2_q400_ff) * 16'd400);
      s2_leap   = (s2_ypos_ff[1:0] == 2'b00) && ((s2_rem100 != '0) || (s2_rem400 == '0));
      s2_yday   = s2_dayb_ff + signed'(c2e_pkg::DAYB_W'(s2_late_ff && s2_leap));
      s2_leaps  = signed'(c2e_pkg::DAYS_W'(s2_lquart_ff))
                  - signed'(c2e_pkg::DAYS_W'(s2_lq100_ff))
                  + signed'(c2e_pkg::DAYS_W'(s2_lq400_ff));
      s2_yrel   = signed'(c2e_pkg::DAYS_W'(s2_ypos_ff))
                  - signed'(c2e_pkg::DAYS_W'(c2e_pkg::EPOCH_YPOS));
      s2_days   = c2e_pkg::DAYS_W'(s2_yday) + s2_yrel * c2e_pkg::DAYS_PER_YEAR
                  + s2_leaps - c2e_pkg::DAYS_BIAS;
   end

   // stage 3: day count
   logic signed [c2e_pkg::DAYS_W-1:0] s3_days_ff;
   logic [c2e_pkg::TOD_W-1:0]         s3_tod_ff;
   logic [c2e_pkg::YDAY_W-1:0]        s3_yday_ff;
   logic                              s3_oor_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s3_days_ff <= s2_days;
         s3_tod_ff  <= s2_tod_ff;
         s3_yday_ff <= s2_yday[c2e_pkg::YDAY_W-1:0];
         s3_oor_ff  <= s2_oor_ff;
      end
   end

   logic signed [c2e_pkg::PROD_W-1:0] s3_prod;
   logic [c2e_pkg::MOD_W-1:0]         s3_mod_in;
   logic [c2e_pkg::WDAY_W-1:0]        s3_wday;

   always_comb begin
      s3_prod   = s3_days_ff * c2e_pkg::SECS_PER_DAY;
      s3_mod_in = c2e_pkg::MOD_W'(s3_days_ff) + c2e_pkg::MOD7_BIAS;
      s3_wday   = c2e_pkg::mod7(s3_mod_in);
   end

   // stage 4: day seconds and weekday
   logic [c2e_pkg::EPOCH_W-1:0] s4_prod_ff;
   logic [c2e_pkg::TOD_W-1:0]   s4_tod_ff;
   logic [c2e_pkg::YDAY_W-1:0]  s4_yday_ff;
   logic [c2e_pkg::WDAY_W-1:0]  s4_wday_ff;
   logic                        s4_oor_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s4_prod_ff <= s3_prod[c2e_pkg::EPOCH_W-1:0];
         s4_tod_ff  <= s3_tod_ff;
         s4_yday_ff <= s3_yday_ff;
         s4_wday_ff <= s3_wday;
         s4_oor_ff  <= s3_oor_ff;
      end
   end

   logic [c2e_pkg::EPOCH_W-1:0] s4_secs;
   logic [c2e_pkg::WDAY_W-1:0]  s4_wday;

   always_comb begin
      if (s4_oor_ff) begin
         s4_secs = '1;
         s4_wday = '0;
      end else begin
         s4_secs = s4_prod_ff + c2e_pkg::EPOCH_W'(s4_tod_ff);
         s4_wday = s4_wday_ff;
      end
   end

   // stage 5: result register
   logic [c2e_pkg::EPOCH_W-1:0] s5_secs_ff;
   logic [c2e_pkg::YDAY_W-1:0]  s5_yday_ff;
   logic [c2e_pkg::WDAY_W-1:0]  s5_wday_ff;
   logic                        s5_oor_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s5_secs_ff <= s4_secs;
         s5_yday_ff <= s4_yday_ff;
         s5_wday_ff <= s4_wday;
         s5_oor_ff  <= s4_oor_ff;
      end
   end

   assign rsp_epoch_seconds = signed'(s5_secs_ff);
   assign rsp_day_of_year   = s5_yday_ff;
   assign rsp_day_of_week   = s5_wday_ff;
   assign rsp_out_of_range  = s5_oor_ff;

endmodule

// ===== design/c2e_div100.sv =====
// Constant divider: floor of a 16-bit year value by 100 and by 400
module c2e_div100 (
   input  logic [c2e_pkg::YPOS_W-1:0] value,
   output logic [c2e_pkg::Q100_W-1:0] quot100,
   output logic [c2e_pkg::Q400_W-1:0] quot400
);

   logic [c2e_pkg::DPROD_W-1:0] prod100;
   logic [c2e_pkg::DPROD_W-1:0] prod400;

   assign prod100 = c2e_pkg::DPROD_W'(value) * c2e_pkg::DPROD_W'(c2e_pkg::RECIP_100);
   assign prod400 = c2e_pkg::DPROD_W'(value) * c2e_pkg::DPROD_W'(c2e_pkg::RECIP_400);

   assign quot100 = prod100[c2e_pkg::SHIFT_100 +: c2e_pkg::Q100_W];
   assign quot400 = prod400[c2e_pkg::SHIFT_400 +: c2e_pkg::Q400_W];

endmodule

// ===== design/c2e_checker.sv =====
// Port-level checker for the calendar to epoch seconds block, with its bind
`include "calendar_to_epoch_seconds_assert.svh"

module c2e_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [5:0]                          req_second,
   input logic [5:0]                          req_minute,
   input logic [4:0]                          req_hour,
   input logic [4:0]                          req_month_day,
   input logic [3:0]                          req_month_index,
   input logic signed [c2e_pkg::YEAR_W-1:0]   req_years_since_1900,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [c2e_pkg::EPOCH_W-1:0]  rsp_epoch_seconds,
   input logic [c2e_pkg::YDAY_W-1:0]          rsp_day_of_year,
   input logic [c2e_pkg::WDAY_W-1:0]          rsp_day_of_week,
   input logic                                rsp_out_of_range
);

   logic oor_shape;
   logic [c2e_pkg::EPOCH_W+c2e_pkg::YDAY_W+c2e_pkg::WDAY_W:0] rsp_data;

   assign oor_shape = (rsp_epoch_seconds == '1) && (rsp_day_of_week == '0);
   assign rsp_data  = {rsp_epoch_seconds, rsp_day_of_year, rsp_day_of_week, rsp_out_of_range};

   `C2E_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `C2E_ASSERT_IMPLY(a_oor_result, clock, reset, rsp_valid && rsp_out_of_range, oor_shape)
   `C2E_ASSERT_IMPLY(a_weekday_range, clock, reset, rsp_valid, rsp_day_of_week != 3'd7)
   `C2E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind calendar_to_epoch_seconds c2e_checker u_c2e_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for calendar_to_epoch_seconds: directed and random dates against a local predictor
module tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LATENCY        = 5;
   localparam int YEAR_SPAN      = 10000;
   localparam int REPORT_LIMIT   = 100;
   localparam int RANDOM_ITEMS   = 1780;
   localparam int MODE_BLOCK     = 60;
   localparam logic [3:0] FEBRUARY = 4'd1;
   localparam logic [3:0] DECEMBER = 4'd11;

   typedef struct {
      logic [5:0]         second;
      logic [5:0]         minute;
      logic [4:0]         hour;
      logic [4:0]         month_day;
      logic [3:0]         month_index;
      logic signed [14:0] years_since_1900;
   } stamp_type;

   typedef struct {
      logic signed [39:0] epoch_seconds;
      logic [8:0]         day_of_year;
      logic [2:0]         day_of_week;
      logic               out_of_range;
   } epoch_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [5:0] req_second;
   logic [5:0] req_minute;
   logic [4:0] req_hour;
   logic [4:0] req_month_day;
   logic [3:0] req_month_index;
   logic signed [c2e_pkg::YEAR_W-1:0] req_years_since_1900;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [c2e_pkg::EPOCH_W-1:0] rsp_epoch_seconds;
   logic [c2e_pkg::YDAY_W-1:0] rsp_day_of_year;
   logic [c2e_pkg::WDAY_W-1:0] rsp_day_of_week;
   logic rsp_out_of_range;

   logic rx_stall;
   logic hold_stall;
   bit   tx_idle;
   bit   rx_idle;
   int   error_count;
   int   idle_cycles;

   epoch_type expected_epochs[$];

   assign rsp_stall = rx_stall | hold_stall;

   calendar_to_epoch_seconds dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_second           (req_second),
      .req_minute           (req_minute),
      .req_hour             (req_hour),
      .req_month_day        (req_month_day),
      .req_month_index      (req_month_index),
      .req_years_since_1900 (req_years_since_1900),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_epoch_seconds    (rsp_epoch_seconds),
      .rsp_day_of_year      (rsp_day_of_year),
      .rsp_day_of_week      (rsp_day_of_week),
      .rsp_out_of_range     (rsp_out_of_range)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   // leap years in 1..n, counting backward for negative n
   function automatic longint leap_count(input longint n);
      return floor_div(n, 4) - floor_div(n, 100) + floor_div(n, 400);
   endfunction

   function automatic epoch_type predict_epoch(input stamp_type s);
      epoch_type e;
      longint yoff;
      longint year;
      longint yday;
      longint days;
      longint secs;
      longint wday;
      logic [3:0] mon;
      yoff = longint'(s.years_since_1900);
      year = yoff + 1900;
      mon = (s.month_index > DECEMBER) ? DECEMBER : s.month_index;
      case (mon)
         4'd0:    yday = 0;
         4'd1:    yday = 31;
         4'd2:    yday = 59;
         4'd3:    yday = 90;
         4'd4:    yday = 120;
         4'd5:    yday = 151;
         4'd6:    yday = 181;
         4'd7:    yday = 212;
         4'd8:    yday = 243;
         4'd9:    yday = 273;
         4'd10:   yday = 304;
         default: yday = 334;
      endcase
      yday = yday + longint'(s.month_day) - 1;
      if (mon > FEBRUARY && year % 4 == 0 && (year % 100 != 0 || year % 400 == 0)) yday++;
      e.day_of_year = yday[8:0];
      if (yoff > YEAR_SPAN || yoff < -YEAR_SPAN) begin
         e.epoch_seconds = '1;
         e.day_of_week   = '0;
         e.out_of_range  = 1'b1;
      end else begin
         days = yday + 365 * (year - 1970) + leap_count(year - 1) - leap_count(1969);
         secs = longint'(s.second) + 60 * longint'(s.minute) + 3600 * longint'(s.hour)
                + 86400 * days;
         wday = (days + 4) % 7;
         if (wday < 0) wday += 7;
         e.epoch_seconds = secs[39:0];
         e.day_of_week   = wday[2:0];
         e.out_of_range  = 1'b0;
      end
      return e;
   endfunction

   function automatic stamp_type make_stamp(input int sec, input int min, input int hr,
                                            input int mday, input int mon, input int yoff);
      stamp_type s;
      s.second           = 6'(sec);
      s.minute           = 6'(min);
      s.hour             = 5'(hr);
      s.month_day        = 5'(mday);
      s.month_index      = 4'(mon);
      s.years_since_1900 = 15'(yoff);
      return s;
   endfunction

   function automatic stamp_type random_stamp();
      stamp_type s;
      int kind;
      int y;
      kind = $urandom_range(0, 9);
      s.second      = 6'($urandom_range(0, 60));
      s.minute      = 6'($urandom_range(0, 59));
      s.hour        = 5'($urandom_range(0, 23));
      s.month_day   = 5'($urandom_range(1, 31));
      s.month_index = 4'($urandom_range(0, 11));
      case (kind)
         0, 1, 2: y = int'($urandom_range(0, 300)) - 100;
         3, 4, 5: y = int'($urandom_range(0, 2 * YEAR_SPAN)) - YEAR_SPAN;
         6: begin
            case ($urandom_range(0, 3))
               0:       y = YEAR_SPAN + int'($urandom_range(0, 2)) - 1;
               1:       y = -YEAR_SPAN + int'($urandom_range(0, 2)) - 1;
               2:       y = -16384;
               default: y = 16383;
            endcase
         end
         7: begin
            y = int'($urandom_range(0, 400)) - 200;
            if ($urandom_range(0, 1)) s.month_day = '0;
            else s.month_index = 4'($urandom_range(12, 15));
         end
         default: begin
            y = int'($urandom_range(0, 32767)) - 16384;
            s.second      = 6'($urandom);
            s.minute      = 6'($urandom);
            s.hour        = 5'($urandom);
            s.month_day   = 5'($urandom);
            s.month_index = 4'($urandom);
         end
      endcase
      s.years_since_1900 = 15'(y);
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic send_stamp(input stamp_type s);
      int gap;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_second           = s.second;
      req_minute           = s.minute;
      req_hour             = s.hour;
      req_month_day        = s.month_day;
      req_month_index      = s.month_index;
      req_years_since_1900 = s.years_since_1900;
      req_valid            = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_epochs.push_back(predict_epoch(s));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_epochs.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic hold_results(input int cycles);
      @(negedge clock);
      hold_stall = 1'b1;
      repeat (cycles) @(negedge clock);
      hold_stall = 1'b0;
   endtask

   task automatic test_directed();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      send_stamp(make_stamp(0, 0, 0, 1, 0, 70));
      send_stamp(make_stamp(59, 59, 23, 31, 11, 69));
      send_stamp(make_stamp(0, 0, 0, 0, 0, 70));
      send_stamp(make_stamp(0, 0, 0, 0, 0, 0));
      send_stamp(make_stamp(63, 63, 31, 31, 15, 16383));
      send_stamp(make_stamp(60, 59, 23, 30, 5, 116));
      send_stamp(make_stamp(0, 0, 0, 29, 1, 124));
      send_stamp(make_stamp(0, 0, 0, 1, 2, 124));
      send_stamp(make_stamp(0, 0, 0, 0, 2, 124));
      send_stamp(make_stamp(0, 0, 0, 1, 2, 100));
      send_stamp(make_stamp(0, 0, 0, 1, 2, 0));
      send_stamp(make_stamp(0, 0, 0, 1, 2, 200));
      send_stamp(make_stamp(0, 0, 0, 31, 11, 99));
      send_stamp(make_stamp(0, 0, 0, 1, 12, 120));
      send_stamp(make_stamp(0, 0, 0, 1, 15, 120));
      send_stamp(make_stamp(7, 8, 9, 10, 3, 10000));
      send_stamp(make_stamp(7, 8, 9, 10, 3, 10001));
      send_stamp(make_stamp(7, 8, 9, 10, 3, -10000));
      send_stamp(make_stamp(7, 8, 9, 10, 3, -10001));
      send_stamp(make_stamp(0, 0, 0, 1, 0, -16384));
      send_stamp(make_stamp(63, 63, 31, 31, 1, -1900));
      send_stamp(make_stamp(0, 0, 0, 31, 10, 138));
      send_stamp(make_stamp(7, 14, 3, 19, 0, 138));
   endtask

   // output held while the input keeps offering, so the pipeline fills and stalls
   task automatic test_backpressure();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      fork
         hold_results(100);
         begin
            for (int i = 0; i < 48; i++) send_stamp(random_stamp());
         end
      join
   endtask

   task automatic test_random();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % MODE_BLOCK == 0) begin
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
         end
         send_stamp(random_stamp());
      end
   endtask

   always @(posedge clock) begin : check_results
      epoch_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_epochs.size() == 0) begin
            report_mismatch("unexpected transfer, epoch_seconds", rsp_epoch_seconds, 0);
         end else begin
            e = expected_epochs.pop_front();
            if (rsp_epoch_seconds !== e.epoch_seconds)
               report_mismatch("epoch_seconds", rsp_epoch_seconds, e.epoch_seconds);
            if (rsp_day_of_year !== e.day_of_year)
               report_mismatch("day_of_year", rsp_day_of_year, e.day_of_year);
            if (rsp_day_of_week !== e.day_of_week)
               report_mismatch("day_of_week", rsp_day_of_week, e.day_of_week);
            if (rsp_out_of_range !== e.out_of_range)
               report_mismatch("out_of_range", rsp_out_of_range, e.out_of_range);
         end
      end
   end

   initial begin : receiver
      int waits;
      rx_stall = 1'b0;
      forever begin
         waits = rx_idle ? $urandom_range(0, 12) : 0;
         repeat (waits) begin
            @(negedge clock);
            rx_stall = 1'b1;
         end
         @(negedge clock);
         rx_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_second           = '0;
      req_minute           = '0;
      req_hour             = '0;
      req_month_day        = '0;
      req_month_index      = '0;
      req_years_since_1900 = '0;
      hold_stall           = 1'b0;
      tx_idle              = 1'b0;
      rx_idle              = 1'b0;
      error_count          = 0;
      idle_cycles          = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      wait_drained();
      test_backpressure();
      wait_drained();
      test_random();
      wait_drained();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/c2e_pkg.sv
design/c2e_div100.sv
design/calendar_to_epoch_seconds.sv
design/c2e_checker.sv
test/tb.sv
